// ===== rtl/chrl_pkg.sv =====
// ----------------------------------------------------------------------------
// chrl_pkg
// Types and constants shared by the consistent hash ring lookup unit and its
// checker: command and result words, ring entry layout, register indexes.
// ----------------------------------------------------------------------------
package chrl_pkg;

	// field widths fixed by the interface
	localparam int ID_W     = 64;
	localparam int SRV_W    = 8;
	localparam int IDX_W    = 10;
	localparam int RCNT_W   = 4;
	localparam int RNUM_W   = 3;
	localparam int SCNT_W   = 9;
	localparam int VPS_W    = 11;
	localparam int CFG_IX_W = 4;
	localparam int CFG_D_W  = 32;

	// upper bound on virtual nodes per server
	localparam int VIRT_LIMIT = 1024;

	// command codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IX_W-1:0] REG_SERVER_COUNT       = 4'd0;
	localparam logic [CFG_IX_W-1:0] REG_VIRTUAL_PER_SERVER = 4'd1;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  entry_index;
		logic [ID_W-1:0]   entry_id;
		logic [SRV_W-1:0]  entry_server;
		logic [ID_W-1:0]   lookup_key;
		logic [RCNT_W-1:0] replica_count;
	} cmd_word_t;

	typedef struct packed {
		logic [SRV_W-1:0]  server_index;
		logic [RNUM_W-1:0] replica_number;
		logic              last;
		logic              count_clamped;
	} res_word_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [SRV_W-1:0] server;
	} ring_entry_t;

endpackage

// ===== rtl/consistent_hash_ring_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_unit
// Ring table of virtual nodes in one synchronous memory. Write commands load
// entries; lookup commands binary-search the ring for a key, then walk it
// forward collecting distinct servers and return one result word per server.
// ----------------------------------------------------------------------------
//
//  channel   signals                          handshake
//  --------  -------------------------------  ---------------------------------
//  command   start, busy, item                taken when start && !busy
//  result    result_valid, result             one-cycle strobe, cannot stall
//  config    cfg_valid, cfg_ready, cfg_index,  taken when cfg_valid && cfg_ready
//            cfg_data                          (cfg_ready is always high)
//
//  a write command leaves busy low. a lookup binary-searches the table, each
//  step a read in ST_SRD and a compare in ST_SCMP, then walks the ring
//  through the registered read and returns its result words back to back;
//  the single table read port sets the pace.
//  reset clears control state and sets both registers to 1; the table is not
//  cleared and holds nothing valid until written.
//
module consistent_hash_ring_lookup_unit #(
	parameter int TABLE_DEPTH  = 1024,
	parameter int MAX_SERVERS  = 256,
	parameter int MAX_REPLICAS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  chrl_pkg::cmd_word_t                 item,
	output logic                                result_valid,
	output chrl_pkg::res_word_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [chrl_pkg::CFG_IX_W-1:0]       cfg_index,
	input  logic [chrl_pkg::CFG_D_W-1:0]        cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = $clog2(MAX_REPLICAS + 1);
	localparam int CW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRD  = 3'd1;
	localparam logic [2:0] ST_SCMP = 3'd2;
	localparam logic [2:0] ST_WALK = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                       state_q;
	logic [chrl_pkg::SCNT_W-1:0]      scnt_q;
	logic [chrl_pkg::VPS_W-1:0]       vps_q;

	// ring memory
	chrl_pkg::ring_entry_t            ring_mem [TABLE_DEPTH];
	chrl_pkg::ring_entry_t            rdata_q;
	logic                             rd_en;
	logic [AW-1:0]                    raddr;
	logic                             wr_en;
	logic [AW-1:0]                    waddr;

	// lookup context
	logic [chrl_pkg::ID_W-1:0]        key_q;
	logic [chrl_pkg::RCNT_W-1:0]      asked_q;
	logic [RW-1:0]                    want_q;
	logic [NW-1:0]                    n_q;
	logic [NW-1:0]                    lo_q;
	logic [NW-1:0]                    hi_q;
	logic [AW-1:0]                    mid_q;
	logic [AW-1:0]                    pos_q;
	logic [NW-1:0]                    iss_q;
	logic [NW-1:0]                    vis_q;
	logic                             rd_v_s1;
	logic [RW-1:0]                    found_q;
	logic [RW-1:0]                    emit_q;
	logic                             clamped_q;
	logic [chrl_pkg::SRV_W-1:0]       chosen_q [MAX_REPLICAS];

	// combinational helpers
	logic                             accept;
	logic [chrl_pkg::SCNT_W-1:0]      eff_s;
	logic [chrl_pkg::VPS_W-1:0]       eff_v;
	logic [chrl_pkg::SCNT_W+chrl_pkg::VPS_W-1:0] prod;
	logic [NW-1:0]                    n_new;
	logic [RW-1:0]                    want_new;
	logic [NW:0]                      lohi_sum;
	logic [AW-1:0]                    mid;
	logic [AW-1:0]                    start_pos;
	logic                             issue;
	logic [AW-1:0]                    pos_next;
	logic                             dup;
	logic [RW-1:0]                    found_next;
	logic [NW-1:0]                    vis_next;
	logic                             walk_done;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// effective register values and used table size
	always_comb begin
		eff_s = scnt_q;
		if (scnt_q == '0) begin
			eff_s = chrl_pkg::SCNT_W'(1);
		end else if (32'(scnt_q) > MAX_SERVERS) begin
			eff_s = chrl_pkg::SCNT_W'(MAX_SERVERS);
		end
		eff_v = vps_q;
		if (vps_q == '0) begin
			eff_v = chrl_pkg::VPS_W'(1);
		end else if (32'(vps_q) > chrl_pkg::VIRT_LIMIT) begin
			eff_v = chrl_pkg::VPS_W'(chrl_pkg::VIRT_LIMIT);
		end
		prod = (chrl_pkg::SCNT_W+chrl_pkg::VPS_W)'(eff_s) *
			(chrl_pkg::SCNT_W+chrl_pkg::VPS_W)'(eff_v);
		if (32'(prod) > TABLE_DEPTH) begin
			n_new = NW'(TABLE_DEPTH);
		end else begin
			n_new = NW'(prod);
		end
	end

	// replicas actually sought
	always_comb begin
		int w;
		w = 32'(item.replica_count);
		if (w > 32'(eff_s)) begin
			w = 32'(eff_s);
		end
		if (w > MAX_REPLICAS) begin
			w = MAX_REPLICAS;
		end
		want_new = RW'(w);
	end

	// search midpoint and start of walk
	assign lohi_sum  = (NW+1)'(lo_q) + (NW+1)'(hi_q);
	assign mid       = AW'(lohi_sum >> 1);
	assign start_pos = (lo_q == '0) ? AW'(n_q - NW'(1)) : AW'(lo_q - NW'(1));

	// walk read issue, one entry a cycle
	assign issue    = (state_q == ST_WALK) && (iss_q < n_q);
	assign pos_next = (32'(pos_q) + 1 >= 32'(n_q)) ? '0 : pos_q + AW'(1);

	// duplicate check against servers already chosen
	always_comb begin
		dup = 1'b0;
		for (int k = 0; k < MAX_REPLICAS; k++) begin
			if (32'(k) < 32'(found_q) && chosen_q[k] == rdata_q.server) begin
				dup = 1'b1;
			end
		end
		found_next = found_q + RW'(!dup);
		vis_next   = vis_q + NW'(1);
		walk_done  = (found_next == want_q) || (vis_next == n_q);
	end

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		raddr = pos_q;
		if (state_q == ST_SRD && lo_q < hi_q) begin
			rd_en = 1'b1;
			raddr = mid;
		end else if (issue) begin
			rd_en = 1'b1;
		end
		wr_en = accept && (item.opcode == chrl_pkg::OP_WRITE) &&
			(32'(item.entry_index) < TABLE_DEPTH);
		waddr = AW'(32'(item.entry_index));
	end

	// ring memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[waddr] <= '{id: item.entry_id, server: item.entry_server};
		end
		if (rd_en) begin
			rdata_q <= ring_mem[raddr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q <= chrl_pkg::SCNT_W'(1);
			vps_q  <= chrl_pkg::VPS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				chrl_pkg::REG_SERVER_COUNT:       scnt_q <= cfg_data[chrl_pkg::SCNT_W-1:0];
				chrl_pkg::REG_VIRTUAL_PER_SERVER: vps_q  <= cfg_data[chrl_pkg::VPS_W-1:0];
				default: ;
			endcase
		end
	end

	// lookup sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lo_q      <= '0;
			hi_q      <= '0;
			mid_q     <= '0;
			pos_q     <= '0;
			iss_q     <= '0;
			vis_q     <= '0;
			rd_v_s1   <= 1'b0;
			found_q   <= '0;
			emit_q    <= '0;
			want_q    <= '0;
			n_q       <= '0;
			asked_q   <= '0;
			clamped_q <= 1'b0;
			key_q     <= '0;
			for (int k = 0; k < MAX_REPLICAS; k++) begin
				chosen_q[k] <= '0;
			end
		end else begin
			rd_v_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (accept && item.opcode == chrl_pkg::OP_LOOKUP && want_new != '0) begin
						key_q   <= item.lookup_key;
						asked_q <= item.replica_count;
						want_q  <= want_new;
						n_q     <= n_new;
						lo_q    <= '0;
						hi_q    <= n_new;
						state_q <= ST_SRD;
					end
				end
				ST_SRD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_SCMP;
					end else begin
						pos_q   <= start_pos;
						iss_q   <= '0;
						vis_q   <= '0;
						found_q <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_SCMP: begin
					if (rdata_q.id <= key_q) begin
						lo_q <= NW'(mid_q) + NW'(1);
					end else begin
						hi_q <= NW'(mid_q);
					end
					state_q <= ST_SRD;
				end
				ST_WALK: begin
					if (issue) begin
						pos_q <= pos_next;
						iss_q <= iss_q + NW'(1);
					end
					if (rd_v_s1) begin
						vis_q <= vis_next;
						if (!dup) begin
							chosen_q[found_q[CW-1:0]] <= rdata_q.server;
						end
						found_q <= found_next;
						if (walk_done) begin
							clamped_q <= 32'(found_next) < 32'(asked_q);
							emit_q    <= '0;
							state_q   <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					emit_q <= emit_q + RW'(1);
					if (emit_q + RW'(1) == found_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result word
	assign result_valid          = (state_q == ST_EMIT);
	assign result.server_index   = chosen_q[emit_q[CW-1:0]];
	assign result.replica_number = chrl_pkg::RNUM_W'(emit_q);
	assign result.last           = (emit_q + RW'(1) == found_q);
	assign result.count_clamped  = clamped_q;

endmodule

// ===== rtl/chrl_checker.sv =====
// ----------------------------------------------------------------------------
// chrl_checker
// Port-level checks on the ring lookup unit: results only while busy, write
// commands finish at once, result words of a lookup come back to back.
// ----------------------------------------------------------------------------
module chrl_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input chrl_pkg::cmd_word_t item,
	input logic                result_valid,
	input chrl_pkg::res_word_t result
);

	// results only appear inside a lookup
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result word outside a lookup");

	// a write command never makes the unit busy
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.opcode == chrl_pkg::OP_WRITE) |=> !busy)
		else $error("write command left the unit busy");

	// nothing follows the last word of a lookup
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |=> !result_valid)
		else $error("result word after last");

	// words of one lookup are consecutive and numbered in order
	a_res_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |=>
		(result_valid && result.replica_number ==
		$past(result.replica_number) + chrl_pkg::RNUM_W'(1)))
		else $error("result words not consecutive");

	// the clamp flag is the same on every word of a lookup
	a_clamp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |=>
		(result.count_clamped == $past(result.count_clamped)))
		else $error("clamp flag changed within a lookup");

endmodule

bind consistent_hash_ring_lookup_unit chrl_checker u_chrl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);
